// ----- src/wpge_pkg.sv -----
// Shared constants, types and command codes of the widest-path graph engine.
package wpge_pkg;
    localparam int NODES      = 1024;
    localparam int EDGES      = 4096;
    localparam int NODE_W     = $clog2(NODES);
    localparam int CAP_W      = 15;
    localparam int NC_W       = 11;
    localparam int EADDR_W    = $clog2(EDGES);
    localparam int ELNK_W     = $clog2(EDGES + 1);
    localparam int HEAP_DEPTH = EDGES + 1;
    localparam int HADDR_W    = $clog2(HEAP_DEPTH);
    localparam int HFILL_W    = $clog2(HEAP_DEPTH + 1);

    localparam logic [CAP_W-1:0] NO_LIMIT = CAP_W'(30001);
    localparam logic [NC_W-1:0]  NC_RESET = NC_W'(1024);

    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_ADD   = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;
    localparam logic [1:0] CMD_NOP   = 2'd3;

    localparam int OP_W = 5;
    localparam logic [OP_W-1:0] OP_NONE      = 5'd0;
    localparam logic [OP_W-1:0] OP_LOAD      = 5'd1;
    localparam logic [OP_W-1:0] OP_SWEEP     = 5'd2;
    localparam logic [OP_W-1:0] OP_VSWEEP    = 5'd3;
    localparam logic [OP_W-1:0] OP_ADD_RD    = 5'd4;
    localparam logic [OP_W-1:0] OP_ADD_WR    = 5'd5;
    localparam logic [OP_W-1:0] OP_QCHK      = 5'd6;
    localparam logic [OP_W-1:0] OP_PUSH_SRC  = 5'd7;
    localparam logic [OP_W-1:0] OP_PUSH_EDGE = 5'd8;
    localparam logic [OP_W-1:0] OP_UP        = 5'd9;
    localparam logic [OP_W-1:0] OP_UP2       = 5'd10;
    localparam logic [OP_W-1:0] OP_POP       = 5'd11;
    localparam logic [OP_W-1:0] OP_POP1      = 5'd12;
    localparam logic [OP_W-1:0] OP_POP2      = 5'd13;
    localparam logic [OP_W-1:0] OP_DN        = 5'd14;
    localparam logic [OP_W-1:0] OP_DN1       = 5'd15;
    localparam logic [OP_W-1:0] OP_DN2       = 5'd16;
    localparam logic [OP_W-1:0] OP_VIS       = 5'd17;
    localparam logic [OP_W-1:0] OP_VIS1      = 5'd18;
    localparam logic [OP_W-1:0] OP_HEAD      = 5'd19;
    localparam logic [OP_W-1:0] OP_EDGE      = 5'd20;
    localparam logic [OP_W-1:0] OP_EDGE1     = 5'd21;
    localparam logic [OP_W-1:0] OP_MISS      = 5'd22;
    localparam logic [OP_W-1:0] OP_OUT       = 5'd23;

    typedef struct packed {
        logic [NODE_W-1:0] node;
        logic [CAP_W-1:0]  cap;
    } t_hent;

    typedef struct packed {
        logic [NODE_W-1:0] dst;
        logic [CAP_W-1:0]  cap;
        logic [ELNK_W-1:0] nxt;
    } t_edge;

    typedef struct packed {
        logic [OP_W-1:0] op;
    } t_ctl;

    typedef struct packed {
        logic sweep_last;
        logic add_full;
        logic q_done;
        logic fill_zero;
        logic heap_full;
        logic up_root;
        logic up_stop;
        logic dn_leaf;
        logic dn_move;
        logic vis_hit;
        logic pop_dst;
        logic edge_end;
        logic to_ok;
    } t_stat;
endpackage

// ----- src/wpge_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module wpge_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ----- src/wpge_ctrl.sv -----
// Controller state machine: sequences clear, add and query operations.
module wpge_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic [1:0]       i_cmd,
    output logic             o_in_ready,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    input  wpge_pkg::t_stat  i_stat,
    output wpge_pkg::t_ctl   o_ctl
);
    import wpge_pkg::*;

    localparam logic [4:0] S_INIT  = 5'd0;
    localparam logic [4:0] S_IDLE  = 5'd1;
    localparam logic [4:0] S_CLR   = 5'd2;
    localparam logic [4:0] S_ADD   = 5'd3;
    localparam logic [4:0] S_ADD2  = 5'd4;
    localparam logic [4:0] S_QCHK  = 5'd5;
    localparam logic [4:0] S_VCLR  = 5'd6;
    localparam logic [4:0] S_QPUSH = 5'd7;
    localparam logic [4:0] S_UP    = 5'd8;
    localparam logic [4:0] S_UP2   = 5'd9;
    localparam logic [4:0] S_POP   = 5'd10;
    localparam logic [4:0] S_POP1  = 5'd11;
    localparam logic [4:0] S_POP2  = 5'd12;
    localparam logic [4:0] S_DN    = 5'd13;
    localparam logic [4:0] S_DN1   = 5'd14;
    localparam logic [4:0] S_DN2   = 5'd15;
    localparam logic [4:0] S_VIS   = 5'd16;
    localparam logic [4:0] S_VIS1  = 5'd17;
    localparam logic [4:0] S_HEAD  = 5'd18;
    localparam logic [4:0] S_EDGE  = 5'd19;
    localparam logic [4:0] S_EDGE1 = 5'd20;
    localparam logic [4:0] S_EDGE2 = 5'd21;
    localparam logic [4:0] S_DONE  = 5'd22;

    logic [4:0] r_state, n_state;
    logic       r_ret_pop, n_ret_pop;
    logic       r_ovalid, n_ovalid;
    logic [4:0] w_ret;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;
    assign w_ret       = r_ret_pop ? S_POP : S_EDGE;

    always_comb begin
        n_state   = r_state;
        n_ret_pop = r_ret_pop;
        n_ovalid  = (r_ovalid && i_out_ready) ? 1'b0 : r_ovalid;
        o_ctl.op  = OP_NONE;
        case (r_state)
            S_INIT, S_CLR: begin
                o_ctl.op = OP_SWEEP;
                if (i_stat.sweep_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_ctl.op = OP_LOAD;
                    case (i_cmd)
                        CMD_CLEAR: n_state = S_CLR;
                        CMD_ADD:   n_state = S_ADD;
                        CMD_QUERY: n_state = S_QCHK;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_ADD: begin
                o_ctl.op = OP_ADD_RD;
                n_state  = i_stat.add_full ? S_IDLE : S_ADD2;
            end
            S_ADD2: begin
                o_ctl.op = OP_ADD_WR;
                n_state  = S_IDLE;
            end
            S_QCHK: begin
                o_ctl.op = OP_QCHK;
                n_state  = i_stat.q_done ? S_DONE : S_VCLR;
            end
            S_VCLR: begin
                o_ctl.op = OP_VSWEEP;
                if (i_stat.sweep_last) n_state = S_QPUSH;
            end
            S_QPUSH: begin
                o_ctl.op  = OP_PUSH_SRC;
                n_ret_pop = 1'b1;
                n_state   = S_UP;
            end
            S_UP: begin
                o_ctl.op = OP_UP;
                n_state  = i_stat.up_root ? w_ret : S_UP2;
            end
            S_UP2: begin
                o_ctl.op = OP_UP2;
                n_state  = i_stat.up_stop ? w_ret : S_UP;
            end
            S_POP: begin
                if (i_stat.fill_zero) begin
                    o_ctl.op = OP_MISS;
                    n_state  = S_DONE;
                end else begin
                    o_ctl.op = OP_POP;
                    n_state  = S_POP1;
                end
            end
            S_POP1: begin
                o_ctl.op = OP_POP1;
                n_state  = S_POP2;
            end
            S_POP2: begin
                o_ctl.op = OP_POP2;
                n_state  = S_DN;
            end
            S_DN: begin
                o_ctl.op = OP_DN;
                n_state  = i_stat.dn_leaf ? S_VIS : S_DN1;
            end
            S_DN1: begin
                o_ctl.op = OP_DN1;
                n_state  = S_DN2;
            end
            S_DN2: begin
                o_ctl.op = OP_DN2;
                n_state  = i_stat.dn_move ? S_DN : S_VIS;
            end
            S_VIS: begin
                o_ctl.op = OP_VIS;
                n_state  = S_VIS1;
            end
            S_VIS1: begin
                o_ctl.op = OP_VIS1;
                if (i_stat.vis_hit)      n_state = S_POP;
                else if (i_stat.pop_dst) n_state = S_DONE;
                else                     n_state = S_HEAD;
            end
            S_HEAD: begin
                o_ctl.op = OP_HEAD;
                n_state  = S_EDGE;
            end
            S_EDGE: begin
                o_ctl.op = OP_EDGE;
                n_state  = i_stat.edge_end ? S_POP : S_EDGE1;
            end
            S_EDGE1: begin
                o_ctl.op = OP_EDGE1;
                n_state  = i_stat.to_ok ? S_EDGE2 : S_EDGE;
            end
            S_EDGE2: begin
                if (!i_stat.vis_hit && !i_stat.heap_full) begin
                    o_ctl.op  = OP_PUSH_EDGE;
                    n_ret_pop = 1'b0;
                    n_state   = S_UP;
                end else begin
                    n_state = S_EDGE;
                end
            end
            S_DONE: begin
                if (!r_ovalid || i_out_ready) begin
                    o_ctl.op = OP_OUT;
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_INIT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_INIT;
            r_ret_pop <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_ret_pop <= n_ret_pop;
            r_ovalid  <= n_ovalid;
        end
    end
endmodule

// ----- src/wpge_dp.sv -----
// Datapath: graph stores, max-heap, visited marks and query registers.
module wpge_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  wpge_pkg::t_ctl                i_ctl,
    output wpge_pkg::t_stat               o_stat,
    input  logic                          i_cfg_we,
    input  logic [wpge_pkg::NC_W-1:0]     i_cfg_wdata,
    input  logic [wpge_pkg::NODE_W-1:0]   i_src_node,
    input  logic [wpge_pkg::NODE_W-1:0]   i_dst_node,
    input  logic [wpge_pkg::CAP_W-1:0]    i_capacity,
    output logic                          o_found,
    output logic [wpge_pkg::CAP_W-1:0]    o_bottleneck,
    output logic                          o_overflow
);
    import wpge_pkg::*;

    logic [NC_W-1:0]    r_node_count;
    logic [ELNK_W-1:0]  r_used;
    logic               r_ovf;
    logic [NODE_W-1:0]  r_sweep;
    logic [NODE_W-1:0]  r_src, r_dst;
    logic [CAP_W-1:0]   r_cap;
    logic [NC_W-1:0]    r_lim;
    logic [HFILL_W-1:0] r_fill;
    logic [HADDR_W-1:0] r_idx;
    t_hent              r_hval, r_bval;
    logic               r_bl, r_rok;
    logic [NODE_W-1:0]  r_cur;
    logic [CAP_W-1:0]   r_ccap, r_res;
    logic [ELNK_W-1:0]  r_edge;
    logic [NODE_W-1:0]  r_eto;
    logic [CAP_W-1:0]   r_ecap;
    logic               r_rfound;
    logic [CAP_W-1:0]   r_rbn;

    logic               w_hd_we;
    logic [NODE_W-1:0]  w_hd_waddr, w_hd_raddr;
    logic [ELNK_W-1:0]  w_hd_wdata, w_hd_rd;
    logic               w_ed_we;
    logic [EADDR_W-1:0] w_ed_waddr, w_ed_raddr;
    t_edge              w_ed_wdata, w_ed_rd;
    logic               w_vs_we, w_vs_wdata, w_vs_rd;
    logic [NODE_W-1:0]  w_vs_waddr, w_vs_raddr;
    logic               w_hp_we;
    logic [HADDR_W-1:0] w_hp_waddr, w_hp_raddr;
    t_hent              w_hp_wdata, w_hp_rd;

    logic [NC_W-1:0]    w_lim;
    logic               w_qbad, w_qsame;
    logic [HFILL_W:0]   w_l, w_r, w_fill_x;
    logic [HADDR_W-1:0] w_par;
    logic [CAP_W-1:0]   w_cmp, w_nres;
    logic               w_pick_r;

    assign w_lim    = (r_node_count < NC_W'(NODES)) ? r_node_count : NC_W'(NODES);
    assign w_qbad   = (NC_W'(r_src) >= w_lim) || (NC_W'(r_dst) >= w_lim);
    assign w_qsame  = (r_src == r_dst);
    assign w_l      = {r_idx, 1'b1};
    assign w_r      = w_l + 1'b1;
    assign w_fill_x = {1'b0, r_fill};
    assign w_par    = HADDR_W'((r_idx - 1'b1) >> 1);
    assign w_cmp    = r_bl ? r_bval.cap : r_hval.cap;
    assign w_pick_r = r_rok && (w_hp_rd.cap > w_cmp);
    assign w_nres   = ((r_cur != r_src) && (r_ccap < r_res)) ? r_ccap : r_res;

    assign o_stat.sweep_last = (r_sweep == NODE_W'(NODES - 1));
    assign o_stat.add_full   = (r_used >= ELNK_W'(EDGES));
    assign o_stat.q_done     = w_qbad || w_qsame;
    assign o_stat.fill_zero  = (r_fill == '0);
    assign o_stat.heap_full  = (r_fill >= HFILL_W'(HEAP_DEPTH));
    assign o_stat.up_root    = (r_idx == '0);
    assign o_stat.up_stop    = (w_hp_rd.cap >= r_hval.cap);
    assign o_stat.dn_leaf    = (w_l >= w_fill_x);
    assign o_stat.dn_move    = w_pick_r || r_bl;
    assign o_stat.vis_hit    = w_vs_rd;
    assign o_stat.pop_dst    = (r_cur == r_dst);
    assign o_stat.edge_end   = (r_edge == '0);
    assign o_stat.to_ok      = (NC_W'(w_ed_rd.dst) < r_lim);

    always_comb begin
        w_hd_we    = 1'b0;
        w_hd_waddr = r_sweep;
        w_hd_wdata = '0;
        w_hd_raddr = r_src;
        w_ed_we    = 1'b0;
        w_ed_waddr = r_used[EADDR_W-1:0];
        w_ed_wdata = '{dst: r_dst, cap: r_cap, nxt: w_hd_rd};
        w_ed_raddr = EADDR_W'(r_edge - 1'b1);
        w_vs_we    = 1'b0;
        w_vs_waddr = r_sweep;
        w_vs_wdata = 1'b0;
        w_vs_raddr = r_cur;
        w_hp_we    = 1'b0;
        w_hp_waddr = r_idx;
        w_hp_wdata = r_hval;
        w_hp_raddr = '0;
        case (i_ctl.op)
            OP_SWEEP:  w_hd_we = 1'b1;
            OP_VSWEEP: w_vs_we = 1'b1;
            OP_ADD_WR: begin
                w_ed_we    = 1'b1;
                w_hd_we    = 1'b1;
                w_hd_waddr = r_src;
                w_hd_wdata = r_used + 1'b1;
            end
            OP_UP: begin
                w_hp_we    = o_stat.up_root;
                w_hp_raddr = w_par;
            end
            OP_UP2: begin
                w_hp_we    = 1'b1;
                w_hp_wdata = o_stat.up_stop ? r_hval : w_hp_rd;
            end
            OP_POP1:   w_hp_raddr = HADDR_W'(r_fill - 1'b1);
            OP_DN: begin
                w_hp_we    = o_stat.dn_leaf;
                w_hp_raddr = w_l[HADDR_W-1:0];
            end
            OP_DN1:    w_hp_raddr = w_r[HADDR_W-1:0];
            OP_DN2: begin
                w_hp_we = 1'b1;
                if (w_pick_r)  w_hp_wdata = w_hp_rd;
                else if (r_bl) w_hp_wdata = r_bval;
                else           w_hp_wdata = r_hval;
            end
            OP_VIS1: begin
                w_vs_we    = !w_vs_rd;
                w_vs_waddr = r_cur;
                w_vs_wdata = 1'b1;
                w_hd_raddr = r_cur;
            end
            OP_EDGE1:  w_vs_raddr = w_ed_rd.dst;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= NC_RESET;
            r_used       <= '0;
            r_ovf        <= 1'b0;
            r_sweep      <= '0;
            r_fill       <= '0;
        end else begin
            if (i_cfg_we) r_node_count <= i_cfg_wdata;
            case (i_ctl.op)
                OP_LOAD: begin
                    r_src   <= i_src_node;
                    r_dst   <= i_dst_node;
                    r_cap   <= i_capacity;
                    r_sweep <= '0;
                end
                OP_SWEEP: begin
                    r_sweep <= r_sweep + 1'b1;
                    if (o_stat.sweep_last) begin
                        r_used <= '0;
                        r_ovf  <= 1'b0;
                    end
                end
                OP_VSWEEP: r_sweep <= r_sweep + 1'b1;
                OP_ADD_RD: if (o_stat.add_full) r_ovf <= 1'b1;
                OP_ADD_WR: r_used <= r_used + 1'b1;
                OP_QCHK: begin
                    r_lim   <= w_lim;
                    r_sweep <= '0;
                    r_res   <= NO_LIMIT;
                    r_fill  <= '0;
                    r_rfound <= !w_qbad;
                    r_rbn   <= w_qbad ? '0 : NO_LIMIT;
                end
                OP_PUSH_SRC: begin
                    r_hval <= '{node: r_src, cap: '0};
                    r_idx  <= r_fill[HADDR_W-1:0];
                    r_fill <= r_fill + 1'b1;
                end
                OP_PUSH_EDGE: begin
                    r_hval <= '{node: r_eto, cap: r_ecap};
                    r_idx  <= r_fill[HADDR_W-1:0];
                    r_fill <= r_fill + 1'b1;
                end
                OP_UP2: if (!o_stat.up_stop) r_idx <= w_par;
                OP_POP1: begin
                    r_cur  <= w_hp_rd.node;
                    r_ccap <= w_hp_rd.cap;
                    r_fill <= r_fill - 1'b1;
                end
                OP_POP2: begin
                    r_hval <= w_hp_rd;
                    r_idx  <= '0;
                end
                OP_DN1: begin
                    r_bval <= w_hp_rd;
                    r_bl   <= (w_hp_rd.cap > r_hval.cap);
                    r_rok  <= (w_r < w_fill_x);
                end
                OP_DN2: begin
                    if (w_pick_r)  r_idx <= w_r[HADDR_W-1:0];
                    else if (r_bl) r_idx <= w_l[HADDR_W-1:0];
                end
                OP_VIS1: begin
                    if (!w_vs_rd) begin
                        r_res <= w_nres;
                        if (o_stat.pop_dst) begin
                            r_rfound <= 1'b1;
                            r_rbn    <= w_nres;
                        end
                    end
                end
                OP_HEAD:  r_edge <= w_hd_rd;
                OP_EDGE1: begin
                    r_eto  <= w_ed_rd.dst;
                    r_ecap <= w_ed_rd.cap;
                    r_edge <= w_ed_rd.nxt;
                end
                OP_MISS: begin
                    r_rfound <= 1'b0;
                    r_rbn    <= '0;
                end
                OP_OUT: begin
                    o_found      <= r_rfound;
                    o_bottleneck <= r_rbn;
                    o_overflow   <= r_ovf;
                end
                default: ;
            endcase
        end
    end

    wpge_ram #(.WIDTH(ELNK_W), .DEPTH(NODES)) u_head (
        .i_clk(i_clk), .i_we(w_hd_we), .i_waddr(w_hd_waddr), .i_wdata(w_hd_wdata),
        .i_raddr(w_hd_raddr), .o_rdata(w_hd_rd)
    );

    wpge_ram #(.WIDTH($bits(t_edge)), .DEPTH(EDGES)) u_edge (
        .i_clk(i_clk), .i_we(w_ed_we), .i_waddr(w_ed_waddr), .i_wdata(w_ed_wdata),
        .i_raddr(w_ed_raddr), .o_rdata(w_ed_rd)
    );

    wpge_ram #(.WIDTH(1), .DEPTH(NODES)) u_vis (
        .i_clk(i_clk), .i_we(w_vs_we), .i_waddr(w_vs_waddr), .i_wdata(w_vs_wdata),
        .i_raddr(w_vs_raddr), .o_rdata(w_vs_rd)
    );

    wpge_ram #(.WIDTH($bits(t_hent)), .DEPTH(HEAP_DEPTH)) u_heap (
        .i_clk(i_clk), .i_we(w_hp_we), .i_waddr(w_hp_waddr), .i_wdata(w_hp_wdata),
        .i_raddr(w_hp_raddr), .o_rdata(w_hp_rd)
    );
endmodule

// ----- src/widest_path_graph_engine.sv -----
// Top level of the widest-path graph engine: controller plus datapath.
//
//   channel  | handshake                  | word
//   ---------+----------------------------+----------------------------------
//   in       | i_in_valid / o_in_ready    | cmd, src_node, dst_node, capacity
//   out      | o_out_valid / i_out_ready  | found, bottleneck, overflow
//   config   | i_cfg_we                   | node_count
//
// Clear runs an adjacency-head sweep. A query runs a visited-mark sweep,
// then heap work for each pop and for each followed edge; the single heap
// RAM port sets its pace. After reset a head sweep runs before the first
// word is taken. A stalled output holds a finished query in DONE.
module widest_path_graph_engine (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [1:0]                    i_cmd,
    input  logic [wpge_pkg::NODE_W-1:0]   i_src_node,
    input  logic [wpge_pkg::NODE_W-1:0]   i_dst_node,
    input  logic [wpge_pkg::CAP_W-1:0]    i_capacity,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_found,
    output logic [wpge_pkg::CAP_W-1:0]    o_bottleneck,
    output logic                          o_overflow,
    input  logic                          i_cfg_we,
    input  logic [wpge_pkg::NC_W-1:0]     i_cfg_wdata
);
    import wpge_pkg::*;

    t_ctl  w_ctl;
    t_stat w_stat;

    wpge_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_cmd(i_cmd), .o_in_ready(o_in_ready),
        .i_out_ready(i_out_ready), .o_out_valid(o_out_valid),
        .i_stat(w_stat), .o_ctl(w_ctl)
    );

    wpge_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_ctl(w_ctl), .o_stat(w_stat),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_src_node(i_src_node), .i_dst_node(i_dst_node), .i_capacity(i_capacity),
        .o_found(o_found), .o_bottleneck(o_bottleneck), .o_overflow(o_overflow)
    );
endmodule

// ----- src/wpge_chk.sv -----
// Port-level checker for the widest-path graph engine, bound to the top level.
module wpge_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic                          o_found,
    input logic [wpge_pkg::CAP_W-1:0]    o_bottleneck,
    input logic                          o_overflow
);
    import wpge_pkg::*;

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output word dropped while stalled");

    a_word_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            $stable(o_found) && $stable(o_bottleneck) && $stable(o_overflow))
        else $error("output word changed while stalled");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_found || (o_bottleneck == '0)))
        else $error("not-found word with nonzero bottleneck");

    a_cap_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_bottleneck <= NO_LIMIT))
        else $error("bottleneck above the no-limit value");
endmodule

bind widest_path_graph_engine wpge_chk u_wpge_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_out_valid(o_out_valid),
    .i_out_ready(i_out_ready), .o_found(o_found), .o_bottleneck(o_bottleneck),
    .o_overflow(o_overflow)
);
